// File: rtl/core/joint_position_pid_unit_assert.svh
// Assertion macros for the joint position PID unit checkers
`ifndef JOINT_POSITION_PID_UNIT_ASSERT_SVH
`define JOINT_POSITION_PID_UNIT_ASSERT_SVH

// antecedent implies consequent in the next cycle, held off during reset
`define JPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jpp check failed");

// antecedent implies consequent in the same cycle, held off during reset
`define JPP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jpp check failed");

// same as JPP_ASSERT_NEXT but also checked while reset is applied
`define JPP_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("jpp check failed");

`endif

// File: rtl/core/jpp_pkg.sv
// Types, constants and microcode table of the joint position PID unit
package jpp_pkg;

  // channel words
  typedef struct packed {
    logic              command;
    logic signed [31:0] measured_angle;
    logic signed [31:0] target_position;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic signed [31:0] position;
    logic signed [31:0] angle_change;
  } out_word_t;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_TARGET = 1'b1;

  // register map, byte address = 4 * index
  localparam int CFG_AW = 5;
  typedef enum logic [2:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_DERIV_GAIN,
    REG_SAMPLE_PERIOD,
    REG_LIMIT_START,
    REG_LIMIT_END,
    REG_INTEG_LIMIT,
    REG_DRIVE_LIMIT
  } reg_idx_t;

  localparam logic [15:0] RST_PROP_GAIN     = 16'd7680;
  localparam logic [15:0] RST_INTEG_GAIN    = 16'd256;
  localparam logic [15:0] RST_DERIV_GAIN    = 16'd0;
  localparam logic [16:0] RST_SAMPLE_PERIOD = 17'd6554;
  localparam logic [30:0] RST_INTEG_LIMIT   = 31'd6553600;
  localparam logic [14:0] RST_DRIVE_LIMIT   = 15'd100;

  // deadband / integral zone, 0.1 in Q16.16
  localparam logic signed [32:0] DEAD_POS = 33'sd6554;
  localparam logic signed [32:0] DEAD_NEG = -33'sd6554;

  localparam logic signed [51:0] ROUND_HALF = 52'sd32768;
  localparam logic signed [51:0] TRUNC_BIAS = 52'sd16777215;

  // sequencer
  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_POS,
    DP_ERR,
    DP_INT,
    DP_TRUNC,
    DP_DRIVE,
    DP_FINISH
  } dp_op_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ERR_SP,
    MUL_P,
    MUL_I,
    MUL_D
  } mul_op_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef logic [3:0] step_t;

  localparam step_t STEP_FINISH = 4'd9;

  typedef struct packed {
    dp_op_t  dp;
    mul_op_t mul;
    acc_op_t acc;
    logic    jmp_timeout;
    step_t   target;
  } uword_t;

  // microprogram for one tick; the multiplier result is used in the next step
  function automatic uword_t ucode_rom(input step_t pc);
    uword_t w;
    w = '{dp: DP_NOP, mul: MUL_NONE, acc: ACC_HOLD, jmp_timeout: 1'b0, target: STEP_FINISH};
    case (pc)
      4'd0: w.dp = DP_POS;
      4'd1: begin
        w.dp          = DP_ERR;
        w.jmp_timeout = 1'b1;
      end
      4'd2: w.mul = MUL_ERR_SP;
      4'd3: begin
        w.dp  = DP_INT;
        w.mul = MUL_P;
      end
      4'd4: begin
        w.acc = ACC_LOAD;
        w.mul = MUL_I;
      end
      4'd5: begin
        w.acc = ACC_ADD;
        w.mul = MUL_D;
      end
      4'd6: w.acc = ACC_SUB;
      4'd7: w.dp  = DP_TRUNC;
      4'd8: w.dp  = DP_DRIVE;
      4'd9: w.dp  = DP_FINISH;
      default: w.dp = DP_FINISH;
    endcase
    return w;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/joint_position_pid_unit.sv
// Top level of the joint position PID unit: microcoded Q16.16 PID controller
//
// Input channel (in_valid / in_stall / in_data): each word is either a target
// (command = 1), which stores the setpoint and restarts the timeout count and
// gives no result, or a control tick (command = 0) carrying the measured joint
// angle, which gives exactly one result word.
// Result channel (out_valid / out_stall / out_data): drive, limit-referenced
// position and saturated angle change, held in an output register.
// A tick runs a 10-step microprogram over one shared 34x18 multiplier and a
// 52-bit accumulator; the next word is taken only after the tick's result has
// been written to the output register. Once TIMEOUT_LEN ticks have passed since
// the last target the PID steps are skipped.
// in_stall is high while a tick is in the sequencer. If out_stall holds the
// previous result, the final step waits until the output register frees up.
// Configuration is to be written over the APB port only while the block is
// idle, which the block does not enforce. Reset (rst_n low, synchronous) restores
// the register defaults, clears all controller state and the output valid.
module joint_position_pid_unit #(
  parameter int TIMEOUT_LEN = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  jpp_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output jpp_pkg::out_word_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jpp_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import jpp_pkg::*;

  localparam int TW = $clog2(TIMEOUT_LEN + 1);
  typedef logic [TW-1:0] tick_cnt_t;
  localparam tick_cnt_t TICK_MAX = TW'(TIMEOUT_LEN);

  // ---------------- configuration registers ----------------
  logic        [15:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic        [16:0] sample_period_r;
  logic signed [31:0] limit_start_r, limit_end_r;
  logic        [30:0] integ_limit_r;
  logic        [14:0] drive_limit_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r     <= RST_PROP_GAIN;
      integ_gain_r    <= RST_INTEG_GAIN;
      deriv_gain_r    <= RST_DERIV_GAIN;
      sample_period_r <= RST_SAMPLE_PERIOD;
      limit_start_r   <= '0;
      limit_end_r     <= '0;
      integ_limit_r   <= RST_INTEG_LIMIT;
      drive_limit_r   <= RST_DRIVE_LIMIT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PROP_GAIN:     prop_gain_r     <= pwdata[15:0];
        REG_INTEG_GAIN:    integ_gain_r    <= pwdata[15:0];
        REG_DERIV_GAIN:    deriv_gain_r    <= pwdata[15:0];
        REG_SAMPLE_PERIOD: sample_period_r <= pwdata[16:0];
        REG_LIMIT_START:   limit_start_r   <= pwdata;
        REG_LIMIT_END:     limit_end_r     <= pwdata;
        REG_INTEG_LIMIT:   integ_limit_r   <= pwdata[30:0];
        REG_DRIVE_LIMIT:   drive_limit_r   <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PROP_GAIN:     prdata = {16'b0, prop_gain_r};
      REG_INTEG_GAIN:    prdata = {16'b0, integ_gain_r};
      REG_DERIV_GAIN:    prdata = {16'b0, deriv_gain_r};
      REG_SAMPLE_PERIOD: prdata = {15'b0, sample_period_r};
      REG_LIMIT_START:   prdata = limit_start_r;
      REG_LIMIT_END:     prdata = limit_end_r;
      REG_INTEG_LIMIT:   prdata = {1'b0, integ_limit_r};
      REG_DRIVE_LIMIT:   prdata = {17'b0, drive_limit_r};
      default:           prdata = '0;
    endcase
  end

  // ---------------- controller state (model state, reset to zero) ----------------
  seq_state_t         state_r, state_nxt;
  step_t              pc_r, pc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] setpoint_r, setpoint_nxt;
  logic signed [31:0] integ_r, integ_nxt;
  logic signed [31:0] prev_err_r, prev_err_nxt;
  logic signed [31:0] prev_angle_r, prev_angle_nxt;
  tick_cnt_t          ticks_r, ticks_nxt;
  logic signed [15:0] last_drive_r, last_drive_nxt;

  // ---------------- datapath temporaries ----------------
  logic signed [31:0] angle_r, angle_nxt;
  logic signed [31:0] pos_r, pos_nxt;
  logic signed [32:0] change_r, change_nxt;   // exact, for the direction gate
  logic signed [31:0] err_r, err_nxt;
  logic               clr_int_r, clr_int_nxt;
  logic signed [32:0] derr_r, derr_nxt;
  logic signed [51:0] prod_r, prod_nxt;
  logic signed [51:0] acc_r, acc_nxt;
  logic signed [27:0] q_r, q_nxt;             // accumulator >> 24, toward zero
  out_word_t          out_data_r, out_data_nxt;

  uword_t uw;
  assign uw = ucode_rom(pc_r);

  assign in_stall  = (state_r == SEQ_RUN);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // equal limits count as start above end
  logic end_above;
  assign end_above = limit_end_r > limit_start_r;

  logic timed_out;
  assign timed_out = ticks_r >= TICK_MAX;

  // ---------------- shared multiplier ----------------
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;

  always_comb begin
    case (uw.mul)
      MUL_ERR_SP: begin
        mul_a = 34'(err_r);
        mul_b = $signed({1'b0, sample_period_r});
      end
      MUL_P: begin
        mul_a = 34'(err_r);
        mul_b = $signed({2'b0, prop_gain_r});
      end
      MUL_I: begin
        mul_a = 34'(integ_r);
        mul_b = $signed({2'b0, integ_gain_r});
      end
      MUL_D: begin
        mul_a = 34'(derr_r);
        mul_b = $signed({2'b0, deriv_gain_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    case (uw.acc)
      ACC_LOAD: acc_nxt = prod_r;
      ACC_ADD:  acc_nxt = acc_r + prod_r;
      ACC_SUB:  acc_nxt = acc_r - prod_r;
      default:  acc_nxt = acc_r;
    endcase
  end

  // ---------------- step arithmetic ----------------
  logic signed [32:0] pos_diff, raw_err;
  logic               dead_lt, dead_le;
  logic signed [51:0] prod_rnd;
  logic signed [34:0] int_step, int_sum, ilim;
  logic signed [27:0] dlim, dclamp;
  logic               gate_off;
  tick_cnt_t          ticks_inc;

  always_comb begin
    pos_diff = end_above ? (33'(limit_start_r) - 33'(angle_r))
                         : (33'(angle_r) - 33'(limit_start_r));

    raw_err = 33'(setpoint_r) - 33'(pos_r);
    dead_lt = (raw_err > DEAD_NEG) && (raw_err < DEAD_POS);
    dead_le = (raw_err >= DEAD_NEG) && (raw_err <= DEAD_POS);

    // round half up, then clamp to +-integ_limit
    prod_rnd = prod_r + ROUND_HALF;
    int_step = 35'(prod_rnd >>> 16);
    int_sum  = 35'(integ_r) + int_step;
    ilim     = $signed({4'b0, integ_limit_r});

    dlim   = $signed({13'b0, drive_limit_r});
    if (q_r > dlim) begin
      dclamp = dlim;
    end else if (q_r < -dlim) begin
      dclamp = -dlim;
    end else begin
      dclamp = q_r;
    end
    gate_off  = end_above ? (change_r > 33'sd0) : (change_r <= 33'sd0);
    ticks_inc = ticks_r + 1'b1;
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt      = state_r;
    pc_nxt         = pc_r;
    out_valid_nxt  = out_valid_r && out_stall;
    setpoint_nxt   = setpoint_r;
    integ_nxt      = integ_r;
    prev_err_nxt   = prev_err_r;
    prev_angle_nxt = prev_angle_r;
    ticks_nxt      = ticks_r;
    last_drive_nxt = last_drive_r;
    angle_nxt      = angle_r;
    pos_nxt        = pos_r;
    change_nxt     = change_r;
    err_nxt        = err_r;
    clr_int_nxt    = clr_int_r;
    derr_nxt       = derr_r;
    q_nxt          = q_r;
    out_data_nxt   = out_data_r;

    case (state_r)
      SEQ_IDLE: begin
        if (in_valid) begin
          if (in_data.command == CMD_TARGET) begin
            setpoint_nxt = in_data.target_position;
            ticks_nxt    = '0;
          end else begin
            angle_nxt = in_data.measured_angle;
            pc_nxt    = '0;
            state_nxt = SEQ_RUN;
          end
        end
      end

      SEQ_RUN: begin
        case (uw.dp)
          DP_POS: begin
            pos_nxt    = sat32(pos_diff);
            change_nxt = 33'(angle_r) - 33'(prev_angle_r);
          end
          DP_ERR: begin
            err_nxt     = dead_lt ? 32'sd0 : sat32(raw_err);
            clr_int_nxt = dead_le;
          end
          DP_INT: begin
            derr_nxt = 33'(err_r) - 33'(prev_err_r);
            if (clr_int_r) begin
              integ_nxt = '0;
            end else if (int_sum > ilim) begin
              integ_nxt = 32'(ilim);
            end else if (int_sum < -ilim) begin
              integ_nxt = 32'(-ilim);
            end else begin
              integ_nxt = 32'(int_sum);
            end
          end
          DP_TRUNC: begin
            if (acc_r[51]) begin
              q_nxt = 28'((acc_r + TRUNC_BIAS) >>> 24);
            end else begin
              q_nxt = 28'(acc_r >>> 24);
            end
          end
          DP_DRIVE: begin
            prev_err_nxt = err_r;
            ticks_nxt    = ticks_inc;
            // zero when moving toward the end limit or on the timeout tick
            if (gate_off || (ticks_inc == TICK_MAX)) begin
              last_drive_nxt = '0;
            end else begin
              last_drive_nxt = 16'(dclamp);
            end
          end
          DP_FINISH: begin
            if (!out_valid_r || !out_stall) begin
              out_valid_nxt             = 1'b1;
              out_data_nxt.drive        = last_drive_r;
              out_data_nxt.position     = pos_r;
              out_data_nxt.angle_change = sat32(change_r);
              prev_angle_nxt            = angle_r;
              state_nxt                 = SEQ_IDLE;
            end
          end
          default: ;
        endcase

        if (uw.dp != DP_FINISH) begin
          if (uw.jmp_timeout && timed_out) begin
            pc_nxt = uw.target;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
      end

      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= SEQ_IDLE;
      pc_r         <= '0;
      out_valid_r  <= 1'b0;
      setpoint_r   <= '0;
      integ_r      <= '0;
      prev_err_r   <= '0;
      prev_angle_r <= '0;
      ticks_r      <= '0;
      last_drive_r <= '0;
    end else begin
      state_r      <= state_nxt;
      pc_r         <= pc_nxt;
      out_valid_r  <= out_valid_nxt;
      setpoint_r   <= setpoint_nxt;
      integ_r      <= integ_nxt;
      prev_err_r   <= prev_err_nxt;
      prev_angle_r <= prev_angle_nxt;
      ticks_r      <= ticks_nxt;
      last_drive_r <= last_drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    angle_r    <= angle_nxt;
    pos_r      <= pos_nxt;
    change_r   <= change_nxt;
    err_r      <= err_nxt;
    clr_int_r  <= clr_int_nxt;
    derr_r     <= derr_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    q_r        <= q_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: rtl/core/jpp_checker.sv
// Port-level checker for the joint position PID unit and its bind
`include "joint_position_pid_unit_assert.svh"

module jpp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input jpp_pkg::in_word_t   in_data,
  input logic                out_valid,
  input logic                out_stall,
  input jpp_pkg::out_word_t  out_data
);
  import jpp_pkg::*;

  // a stalled result stays put
  `JPP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // a tick occupies the sequencer
  `JPP_ASSERT_NEXT(a_tick_busy, in_valid && !in_stall && in_data.command == CMD_TICK, in_stall)
  // a target completes in its own cycle
  `JPP_ASSERT_NEXT(a_target_free, in_valid && !in_stall && in_data.command == CMD_TARGET, !in_stall)
  // drive is saturated to a 15-bit magnitude
  `JPP_ASSERT_SAME(a_drive_range, out_valid, out_data.drive != 16'sh8000)
  // reset leaves both channels quiet
  `JPP_ASSERT_RST(a_reset_quiet, !rst_n, !out_valid && !in_stall)

endmodule

bind joint_position_pid_unit jpp_checker u_jpp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
